FILE: src/assert_macros.svh
// ----------------------------------------------------------------------------
// assertion macros
// concurrent checks that vanish in synthesis builds
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle implication failed");

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle implication failed");

`else

`define ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

FILE: src/itr_pkg.sv
// ----------------------------------------------------------------------------
// itr_pkg
// fixed widths and codes of the interpolated table reader
// ----------------------------------------------------------------------------
package itr_pkg;

   localparam int SAMPLE_W   = 24;
   localparam int POSITION_W = 29;
   localparam int LOAD_ADDR_W = 14;
   localparam int CHSEL_W    = 2;
   localparam int CHCNT_W    = 3;
   localparam int FRCNT_W    = 13;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 13;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_CHANNEL_SELECT = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_CHANNEL_COUNT  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_FRAME_COUNT    = 2'd2;

   // commands
   localparam logic CMD_LOAD   = 1'b0;
   localparam logic CMD_LOOKUP = 1'b1;

   // register reset values
   localparam logic [CHSEL_W-1:0] CHSEL_RESET = 2'd0;
   localparam logic [CHCNT_W-1:0] CHCNT_RESET = 3'd1;
   localparam logic [FRCNT_W-1:0] FRCNT_RESET = 13'd4096;

endpackage

FILE: src/interpolated_table_reader.sv
// ----------------------------------------------------------------------------
// interpolated_table_reader: interleaved sample table with linear interpolation
// path: an accepted lookup word passes stages 1 to 6 and then shows on rsp
// throughput: one word per cycle unless rsp_ready stalls the pipe; the table reads both frames together
// reset clears config to defaults and empties the pipeline; table not cleared
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module interpolated_table_reader
   import itr_pkg::*;
#(
   parameter int MAX_FRAMES    = 4096,
   parameter int MAX_CHANNELS  = 4,
   parameter int FRACTION_BITS = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic                          req_cmd,
   input  logic        [LOAD_ADDR_W-1:0] req_load_address,
   input  logic signed [SAMPLE_W-1:0]    req_load_sample,
   input  logic signed [POSITION_W-1:0]  req_position,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic signed [SAMPLE_W-1:0]    rsp_sample,
   input  logic                          csr_write_enable,
   input  logic        [CSR_IDX_W-1:0]   csr_index,
   input  logic        [CSR_DATA_W-1:0]  csr_write_data
);

   localparam int DEPTH   = MAX_FRAMES * MAX_CHANNELS;
   localparam int ADDR_W  = $clog2(DEPTH);
   localparam int FRAME_W = $clog2(MAX_FRAMES);
   localparam int NF_W    = $clog2(MAX_FRAMES + 1);
   localparam int IP_W    = POSITION_W - 1 - FRACTION_BITS;
   localparam int DIFF_W  = SAMPLE_W + 1;
   localparam int PROD_W  = DIFF_W + FRACTION_BITS + 1;
   localparam logic [PROD_W-1:0] ROUND_HALF = PROD_W'(1) << (FRACTION_BITS - 1);

   // ---------------------------------------------------------------- config
   logic [CHSEL_W-1:0] channel_select_ff;
   logic [CHCNT_W-1:0] channel_count_ff;
   logic [FRCNT_W-1:0] frame_count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         channel_select_ff <= CHSEL_RESET;
         channel_count_ff  <= CHCNT_RESET;
         frame_count_ff    <= FRCNT_RESET;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            REG_CHANNEL_SELECT: channel_select_ff <= csr_write_data[CHSEL_W-1:0];
            REG_CHANNEL_COUNT:  channel_count_ff  <= csr_write_data[CHCNT_W-1:0];
            REG_FRAME_COUNT:    frame_count_ff    <= csr_write_data[FRCNT_W-1:0];
            default: ;
         endcase
      end
   end

   // clamped config; the user keeps it static while words are in flight, not enforced
   logic [CHCNT_W-1:0] nc_eff;
   logic [CHSEL_W-1:0] ch_eff;
   logic [NF_W-1:0]    nf_eff;

   always_comb begin
      if (channel_count_ff == '0) begin
         nc_eff = CHCNT_W'(1);
      end else if (32'(channel_count_ff) > 32'(MAX_CHANNELS)) begin
         nc_eff = CHCNT_W'(MAX_CHANNELS);
      end else begin
         nc_eff = channel_count_ff;
      end
      if ({1'b0, channel_select_ff} >= nc_eff) begin
         ch_eff = CHSEL_W'(nc_eff - CHCNT_W'(1));
      end else begin
         ch_eff = channel_select_ff;
      end
      if (frame_count_ff == '0) begin
         nf_eff = NF_W'(1);
      end else if (32'(frame_count_ff) > 32'(MAX_FRAMES)) begin
         nf_eff = NF_W'(MAX_FRAMES);
      end else begin
         nf_eff = NF_W'(frame_count_ff);
      end
   end

   // whole pipeline advances together
   logic out_vld_ff;
   logic en;

   assign en        = !out_vld_ff || rsp_ready;
   assign req_ready = en;

   // ------------------------------------------------- stage 1: position decode
   logic                      s1_vld_ff;
   logic                      s1_cmd_ff;
   logic [LOAD_ADDR_W-1:0]    s1_laddr_ff;
   logic [SAMPLE_W-1:0]       s1_lsample_ff;
   logic [FRAME_W-1:0]        s1_frame_ff, s1_frame_in;
   logic [FRACTION_BITS-1:0]  s1_frac_ff, s1_frac_in;
   logic [IP_W-1:0]           int_part;

   always_comb begin
      int_part    = req_position[POSITION_W-2:FRACTION_BITS];
      s1_frame_in = '0;
      s1_frac_in  = '0;
      // negative, zero or out-of-range positions read frame 0 flat
      if (!req_position[POSITION_W-1] && (32'(int_part) < 32'(nf_eff))) begin
         s1_frame_in = FRAME_W'(int_part);
         s1_frac_in  = req_position[FRACTION_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
      end else if (en) begin
         s1_vld_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s1_cmd_ff     <= req_cmd;
         s1_laddr_ff   <= req_load_address;
         s1_lsample_ff <= req_load_sample;
         s1_frame_ff   <= s1_frame_in;
         s1_frac_ff    <= s1_frac_in;
      end
   end

   // ---------------------------------------------------- stage 2: addressing
   logic                     s2_vld_ff;
   logic                     s2_cmd_ff;
   logic                     s2_wr_ok_ff, s2_wr_ok_in;
   logic [ADDR_W-1:0]        s2_a_addr_ff, s2_a_addr_in;
   logic [ADDR_W-1:0]        s2_b_addr_ff, s2_b_addr_in;
   logic [SAMPLE_W-1:0]      s2_lsample_ff;
   logic [FRACTION_BITS-1:0] s2_frac_ff;
   logic [FRAME_W:0]         next_frame;
   logic [FRAME_W-1:0]       next_eff;

   always_comb begin
      next_frame = {1'b0, s1_frame_ff} + (FRAME_W + 1)'(1);
      if (32'(next_frame) >= 32'(nf_eff)) begin
         next_eff = '0;
      end else begin
         next_eff = FRAME_W'(next_frame);
      end
      s2_wr_ok_in  = 32'(s1_laddr_ff) < 32'(DEPTH);
      s2_b_addr_in = ADDR_W'(next_eff) * ADDR_W'(nc_eff) + ADDR_W'(ch_eff);
      if (s1_cmd_ff == CMD_LOAD) begin
         s2_a_addr_in = ADDR_W'(s1_laddr_ff);
      end else begin
         s2_a_addr_in = ADDR_W'(s1_frame_ff) * ADDR_W'(nc_eff) + ADDR_W'(ch_eff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_vld_ff <= 1'b0;
      end else if (en) begin
         s2_vld_ff <= s1_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s2_cmd_ff     <= s1_cmd_ff;
         s2_wr_ok_ff   <= s2_wr_ok_in;
         s2_a_addr_ff  <= s2_a_addr_in;
         s2_b_addr_ff  <= s2_b_addr_in;
         s2_lsample_ff <= s1_lsample_ff;
         s2_frac_ff    <= s1_frac_ff;
      end
   end

   // ------------------------------------------------- stage 3: table access
   // loads write here, lookups read here, so later lookups see earlier loads
   logic [SAMPLE_W-1:0]      sample_table_ff [DEPTH];
   logic                     s3_vld_ff;
   logic [SAMPLE_W-1:0]      s3_a_ff, s3_b_ff;
   logic [FRACTION_BITS-1:0] s3_frac_ff;

   always_ff @(posedge clock) begin
      if (en && s2_vld_ff && (s2_cmd_ff == CMD_LOAD) && s2_wr_ok_ff) begin
         sample_table_ff[s2_a_addr_ff] <= s2_lsample_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s3_a_ff    <= sample_table_ff[s2_a_addr_ff];
         s3_b_ff    <= sample_table_ff[s2_b_addr_ff];
         s3_frac_ff <= s2_frac_ff;
      end
   end

   // only lookups carry on past the table
   always_ff @(posedge clock) begin
      if (reset) begin
         s3_vld_ff <= 1'b0;
      end else if (en) begin
         s3_vld_ff <= s2_vld_ff && (s2_cmd_ff == CMD_LOOKUP);
      end
   end

   // ---------------------------------------------------- stage 4: difference
   logic                     s4_vld_ff;
   logic signed [DIFF_W-1:0] s4_diff_ff, s4_diff_in;
   logic [SAMPLE_W-1:0]      s4_a_ff;
   logic [FRACTION_BITS-1:0] s4_frac_ff;

   assign s4_diff_in = $signed({s3_b_ff[SAMPLE_W-1], s3_b_ff})
                     - $signed({s3_a_ff[SAMPLE_W-1], s3_a_ff});

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_vld_ff <= 1'b0;
      end else if (en) begin
         s4_vld_ff <= s3_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s4_diff_ff <= s4_diff_in;
         s4_a_ff    <= s3_a_ff;
         s4_frac_ff <= s3_frac_ff;
      end
   end

   // ------------------------------------------------------- stage 5: product
   logic                     s5_vld_ff;
   logic signed [PROD_W-1:0] s5_prod_ff, s5_prod_in;
   logic [SAMPLE_W-1:0]      s5_a_ff;

   assign s5_prod_in = s4_diff_ff * $signed({1'b0, s4_frac_ff});

   always_ff @(posedge clock) begin
      if (reset) begin
         s5_vld_ff <= 1'b0;
      end else if (en) begin
         s5_vld_ff <= s4_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s5_prod_ff <= s5_prod_in;
         s5_a_ff    <= s4_a_ff;
      end
   end

   // ------------------------------------------------- stage 6: round and add
   logic [PROD_W-1:0]   rounded;
   logic [SAMPLE_W-1:0] out_sample_ff, out_sample_in;

   // round half up, then floor shift; low sample bits are all that matter
   assign rounded       = s5_prod_ff + ROUND_HALF;
   assign out_sample_in = s5_a_ff + rounded[FRACTION_BITS +: SAMPLE_W];

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else if (en) begin
         out_vld_ff <= s5_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         out_sample_ff <= out_sample_in;
      end
   end

   assign rsp_valid  = out_vld_ff;
   assign rsp_sample = out_sample_ff;

   // ------------------------------------------------------------- checks
   `ASSERT_NEXT(a_load_gives_no_word, clock, reset,
                en && s2_vld_ff && (s2_cmd_ff == CMD_LOAD), !s3_vld_ff)
   `ASSERT_IMPLIES(a_frame_in_range, clock, reset,
                   s1_vld_ff && (s1_cmd_ff == CMD_LOOKUP),
                   32'(s1_frame_ff) < 32'(nf_eff))
   `ASSERT_IMPLIES(a_addr_in_table, clock, reset,
                   s2_vld_ff && (s2_cmd_ff == CMD_LOOKUP),
                   (32'(s2_a_addr_ff) < 32'(DEPTH)) && (32'(s2_b_addr_ff) < 32'(DEPTH)))
   `ASSERT_NEXT(a_stall_holds_pipe, clock, reset, !en,
                $stable(s3_a_ff) && $stable(s5_vld_ff) && $stable(s5_prod_ff))
   `ASSERT_NEXT(a_empty_after_reset, clock, 1'b0, reset, !rsp_valid && !s3_vld_ff)

endmodule
